/* hdl/sbbf_pkg.sv */
// sbbf_pkg: shared types, constants and helper functions for the split-block bloom filter
// used by every module of the filter core except sbbf_ram, and by its checker
`default_nettype none

package sbbf_pkg;

    localparam int WORDS   = 8;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 5;
    localparam int BLOCK_W = WORDS * WORD_W;
    localparam int NB_W    = 11;
    localparam int KEY_W   = 32;
    localparam int POS_LSB = 27;

    localparam logic [NB_W-1:0] NB_RESET = 11'd1024;

    localparam logic [WORD_W-1:0] SALT [WORDS] = '{
        32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
        32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
    };

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_FIND   = 1'b1
    } req_t;

    typedef logic [WORDS-1:0][POS_W-1:0] pos_vec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // bit number inside each word, one salted multiply per lane
    function automatic pos_vec_t calc_pos(input logic [KEY_W-1:0] key);
        pos_vec_t          pos;
        logic [WORD_W-1:0] prod;
        for (int i = 0; i < WORDS; i++)
        begin
            prod   = key * SALT[i];
            pos[i] = prod[POS_LSB +: POS_W];
        end
        return pos;
    endfunction

    function automatic logic [BLOCK_W-1:0] build_mask(input pos_vec_t pos);
        logic [BLOCK_W-1:0] mask;
        for (int i = 0; i < WORDS; i++)
        begin
            mask[i*WORD_W +: WORD_W] = WORD_W'(1) << pos[i];
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

/* hdl/sbbf_ram.sv */
// sbbf_ram: generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module sbbf_ram #(
    parameter int WIDTH  = 256,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/sbbf_fifo.sv */
// sbbf_fifo: two-entry queue between the front and back parts of the filter
// depends on sbbf_pkg for the status struct
`default_nettype none

module sbbf_fifo
    import sbbf_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output q_status_t             status
);

    logic [WIDTH-1:0] data_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = data_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

endmodule

`default_nettype wire

/* hdl/sbbf_front.sv */
// sbbf_front: accepts items, maps the hash to a block index and eight bit numbers
// depends on sbbf_pkg; feeds sbbf_fifo
`default_nettype none

module sbbf_front
    import sbbf_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024,
    parameter int IDX_W      = 10,
    parameter int ENTRY_W    = 1 + IDX_W + WORDS * POS_W
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [NB_W-1:0]    num_blocks,
    input  wire logic               clearing,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               req_type,
    input  wire logic [63:0]        hash_value,
    input  wire q_status_t          q_status,
    output logic                    q_push,
    output logic      [ENTRY_W-1:0] q_entry
);

    localparam logic [31:0] MAX_B32 = 32'(MAX_BLOCKS);

    logic             vld_reg, vld_next;
    logic             req_reg;
    logic [IDX_W-1:0] idx_reg;
    pos_vec_t         pos_reg;

    logic [NB_W-1:0]  nb;
    logic [63:0]      blk_prod;
    logic             accept;

    // block count saturates at the store depth
    always_comb
    begin
        nb = num_blocks;
        if (32'(num_blocks) > MAX_B32)
        begin
            nb = MAX_B32[NB_W-1:0];
        end
        blk_prod = {32'd0, hash_value[63:32]} * {{(64-NB_W){1'b0}}, nb};
    end

    assign in_stall = clearing || (vld_reg && q_status.full);
    assign accept   = in_valid && !in_stall;
    assign q_push   = vld_reg && !q_status.full;
    assign q_entry  = {req_reg, idx_reg, pos_reg};

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (q_push)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            idx_reg <= blk_prod[32 +: IDX_W];
            pos_reg <= calc_pos(hash_value[KEY_W-1:0]);
        end
    end

endmodule

`default_nettype wire

/* hdl/sbbf_back.sv */
// sbbf_back: clearing pass, block read-modify-write for inserts and bit tests for finds
// depends on sbbf_pkg and sbbf_ram; drains sbbf_fifo
`default_nettype none

module sbbf_back
    import sbbf_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024,
    parameter int IDX_W      = 10,
    parameter int ENTRY_W    = 1 + IDX_W + WORDS * POS_W
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire q_status_t          q_status,
    input  wire logic [ENTRY_W-1:0] q_entry,
    output logic                    q_pop,
    output logic                    clearing,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    found
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_addr_reg, clr_addr_next;
    logic             req_reg, req_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    pos_vec_t         pos_reg, pos_next;
    logic             out_vld_reg, out_vld_next;
    logic             found_reg, found_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [BLOCK_W-1:0] ram_wdata;
    logic               ram_re;
    logic [BLOCK_W-1:0] ram_rdata;
    logic [BLOCK_W-1:0] mask;
    logic               hit;
    logic               out_free;

    logic               e_req;
    logic [IDX_W-1:0]   e_idx;
    pos_vec_t           e_pos;

    assign {e_req, e_idx, e_pos} = q_entry;

    sbbf_ram #(
        .WIDTH  (BLOCK_W),
        .DEPTH  (MAX_BLOCKS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (e_idx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        mask = build_mask(pos_reg);
        hit  = 1'b1;
        for (int w = 0; w < WORDS; w++)
        begin
            if ((ram_rdata[w*WORD_W +: WORD_W] & mask[w*WORD_W +: WORD_W]) == '0)
            begin
                hit = 1'b0;
            end
        end
    end

    assign out_free = !out_vld_reg || !out_stall;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        req_next      = req_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        found_next    = found_reg;
        out_vld_next  = out_vld_reg && out_stall;
        q_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = ram_rdata | mask;
        ram_re        = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop      = 1'b1;
                    ram_re     = 1'b1;
                    req_next   = e_req;
                    idx_next   = e_idx;
                    pos_next   = e_pos;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (req_reg == REQ_INSERT)
                begin
                    ram_we     = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    // read data holds while the result slot is taken
                    out_vld_next = 1'b1;
                    found_next   = hit;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
    end

    assign clearing  = (state_reg == ST_CLEAR);
    assign out_valid = out_vld_reg;
    assign found     = found_reg;

endmodule

`default_nettype wire

/* hdl/split_block_bloom_filter_core.sv */
// split_block_bloom_filter_core: top level of the split-block bloom filter
// depends on sbbf_pkg, sbbf_front, sbbf_fifo, sbbf_back and sbbf_ram
//
// Split-block bloom filter over MAX_BLOCKS blocks of eight 32-bit words. Each transfer on the
// input carries a 64-bit hash and a request: insert sets one bit in each word of the chosen
// block and gives nothing back, find tests those eight bits and gives one transfer of found.
// The block is ((hash >> 32) * num_blocks) >> 32, with num_blocks saturated at MAX_BLOCKS.
// After reset a clearing pass zeroes the store, one block per cycle, while in_stall is held
// high; num_blocks may be written during it. The back end then reads the block of an item in
// its idle state and does the write-back or the bit test in its exec state, and takes no new
// item until it is through with the last. The front end maps the next hashes meanwhile and a
// two-entry queue keeps it running while a find result waits on out_stall.
`default_nettype none

module split_block_bloom_filter_core
    import sbbf_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_wr_en,
    input  wire logic [NB_W-1:0] cfg_wr_data,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic            req_type,
    input  wire logic [63:0]     hash_value,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic                 found
);

    localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int ENTRY_W = 1 + IDX_W + WORDS * POS_W;

    logic [NB_W-1:0]    num_blocks_reg;
    logic               clearing;
    logic               q_push;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_in;
    logic [ENTRY_W-1:0] q_out;
    q_status_t          q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_blocks_reg <= NB_RESET;
        end
        else if (cfg_wr_en)
        begin
            num_blocks_reg <= cfg_wr_data;
        end
    end

    sbbf_front #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .IDX_W      (IDX_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .num_blocks (num_blocks_reg),
        .clearing   (clearing),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .hash_value (hash_value),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_entry    (q_in)
    );

    sbbf_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .status    (q_status)
    );

    sbbf_back #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .IDX_W      (IDX_W),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_entry   (q_out),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found)
    );

endmodule

`default_nettype wire

/* hdl/sbbf_checker.sv */
// sbbf_checker: port-level assertions for the filter core, bound to the top level
// depends on sbbf_pkg and split_block_bloom_filter_core
`default_nettype none

module sbbf_checker
    import sbbf_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
) (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_stall,
    input wire logic            req_type,
    input wire logic            out_valid,
    input wire logic            out_stall,
    input wire logic            found
);

    logic [3:0]  pend_reg, pend_next;
    logic [31:0] cyc_reg, cyc_next;
    logic        find_in;
    logic        res_out;

    assign find_in = in_valid && !in_stall && (req_type == REQ_FIND);
    assign res_out = out_valid && !out_stall;

    always_comb
    begin
        pend_next = pend_reg + {3'd0, find_in} - {3'd0, res_out};
        cyc_next  = cyc_reg;
        if (cyc_reg < 32'(MAX_BLOCKS))
        begin
            cyc_next = cyc_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            cyc_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            cyc_reg  <= cyc_next;
        end
    end

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found))
        else $error("found changed while stalled");

    // every result answers an earlier find transfer
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 4'd0)
        else $error("result without a pending find");

    // inserts never produce a result
    a_insert_silent: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 4'd0 && !find_in |=> !out_valid)
        else $error("result with no find outstanding");

    // input is held off for the whole clearing pass
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cyc_reg < 32'(MAX_BLOCKS) |-> in_stall)
        else $error("input taken during clearing pass");

endmodule

bind split_block_bloom_filter_core sbbf_checker #(.MAX_BLOCKS(MAX_BLOCKS)) u_sbbf_checker (.*);

`default_nettype wire

/* sim/sbbf_membership_checker.sv */
`timescale 1ns / 1ps
// sbbf_membership_checker: watches the hash and found channels of the bloom filter core,
// keeps its own copy of the block store and block count, and checks each found transfer in order
// depends on sbbf_pkg for the request codes and the block count width

module sbbf_membership_checker
    import sbbf_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_wr_en,
    input  wire logic [NB_W-1:0] cfg_wr_data,
    input  wire logic            in_valid,
    input  wire logic            in_stall,
    input  wire logic            req_type,
    input  wire logic [63:0]     hash_value,
    input  wire logic            out_valid,
    input  wire logic            out_stall,
    input  wire logic            found,
    output int                   mismatches,
    output int                   pending
);

    // per-word multipliers of the split-block scheme
    localparam logic [31:0] LANE_SALT [8] = '{
        32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
        32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
    };

    logic [255:0]    model_blocks [MAX_BLOCKS];
    logic [NB_W-1:0] model_nb;
    logic            found_expected [$];
    int              results_seen;

    initial
    begin
        mismatches   = 0;
        pending      = 0;
        results_seen = 0;
    end

    // one bit per 32-bit word, picked by the top five bits of key * salt
    function automatic logic [255:0] probe_mask(input logic [31:0] key);
        logic [255:0] mask;
        logic [31:0]  prod;
        mask = '0;
        for (int i = 0; i < 8; i++)
        begin
            prod = key * LANE_SALT[i];
            mask[i*32 + prod[31:27]] = 1'b1;
        end
        return mask;
    endfunction

    function automatic int block_of(input logic [63:0] h, input logic [NB_W-1:0] nb);
        logic [63:0] eff;
        logic [63:0] idx;
        eff = (nb > MAX_BLOCKS) ? 64'(MAX_BLOCKS) : 64'(nb);
        idx = ({32'd0, h[63:32]} * eff) >> 32;
        if (idx >= MAX_BLOCKS)
            idx = '0;
        return int'(idx);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        int           blk;
        logic [255:0] mask;
        logic         want;
        if (!rst_n)
        begin
            for (int b = 0; b < MAX_BLOCKS; b++)
                model_blocks[b] = '0;
            model_nb = NB_RESET;
            found_expected.delete();
        end
        else
        begin
            if (cfg_wr_en)
                model_nb = cfg_wr_data;
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (found_expected.size() == 0)
                    report_mismatch($sformatf("result %0d: found=%0b with no find outstanding",
                                              results_seen, found));
                else
                begin
                    want = found_expected.pop_front();
                    if (found !== want)
                        report_mismatch($sformatf("result %0d: found=%0b, predicted %0b",
                                                  results_seen, found, want));
                end
            end
            if (in_valid && !in_stall)
            begin
                blk  = block_of(hash_value, model_nb);
                mask = probe_mask(hash_value[31:0]);
                if (req_type == REQ_INSERT)
                    model_blocks[blk] = model_blocks[blk] | mask;
                else
                    found_expected.push_back((model_blocks[blk] & mask) == mask);
            end
        end
        pending = found_expected.size();
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// tb: stimulus and verdict for split_block_bloom_filter_core
// depends on sbbf_pkg, the core and sbbf_membership_checker

module tb;
    import sbbf_pkg::*;

    localparam int MAX_BLOCKS    = 1024;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_ITEMS   = 40;

    logic            clk         = 1'b0;
    logic            rst_n       = 1'b0;
    logic            cfg_wr_en   = 1'b0;
    logic [NB_W-1:0] cfg_wr_data = '0;
    logic            in_valid    = 1'b0;
    logic            req_type    = REQ_INSERT;
    logic [63:0]     hash_value  = '0;
    logic            out_stall   = 1'b0;
    logic            in_stall;
    logic            out_valid;
    logic            found;

    int              mismatches;
    int              pending;
    int              burst_left  = 0;
    logic [63:0]     inserted_pool [$];

    logic            stalling    = 1'b0;
    int              run_left    = 0;

    split_block_bloom_filter_core #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .hash_value  (hash_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found)
    );

    sbbf_membership_checker #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) membership_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .hash_value  (hash_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    always #6 clk = ~clk;

    // receiver: alternating free and stalled runs, now and then a long free stretch
    always @(posedge clk)
    begin
        if (run_left > 0)
            run_left--;
        else
        begin
            stalling = !stalling;
            if (stalling)
                run_left = $urandom_range(1, 6);
            else
                run_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 15);
            out_stall <= stalling;
        end
    end

    task automatic write_blocks(input logic [NB_W-1:0] nb);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= nb;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // sender works in bursts; payload is scrambled while idle
    task automatic send_hash(input req_t req, input logic [63:0] h);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                in_valid   <= 1'b0;
                req_type   <= 1'($urandom_range(0, 1));
                hash_value <= {$urandom, $urandom};
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        hash_value <= h;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
    endtask

    // drain outstanding finds, then let trailing inserts finish their write-back
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        // let the checker count the last transfer before polling pending
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [NB_W-1:0] nb);
        logic [63:0] h;
        int          pick;
        int          upper;
        write_blocks(nb);
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            h     = {$urandom, $urandom};
            upper = $urandom_range(0, 9);
            if (upper == 0)
                h[63:32] = '1;
            else if (upper == 1)
                h[63:32] = '0;
            pick = $urandom_range(0, 99);
            if (pick < 40 || inserted_pool.size() == 0)
            begin
                send_hash(REQ_INSERT, h);
                inserted_pool.push_back(h);
                if (inserted_pool.size() > 64)
                    void'(inserted_pool.pop_front());
            end
            else if (pick < 75)
                send_hash(REQ_FIND, inserted_pool[$urandom_range(0, inserted_pool.size() - 1)]);
            else if (pick < 92)
                send_hash(REQ_FIND, h);
            else
                send_hash(REQ_INSERT, inserted_pool[$urandom_range(0, inserted_pool.size() - 1)]);
        end
        settle();
    endtask

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // written while the store is still being cleared
        write_blocks(NB_RESET);

        // empty filter, zero and all-ones hashes, top and bottom blocks
        send_hash(REQ_FIND,   64'h0000000000000000);
        send_hash(REQ_INSERT, 64'h0000000000000000);
        send_hash(REQ_FIND,   64'h0000000000000000);
        send_hash(REQ_FIND,   64'hffffffffffffffff);
        send_hash(REQ_INSERT, 64'hffffffffffffffff);
        send_hash(REQ_FIND,   64'hffffffffffffffff);
        send_hash(REQ_INSERT, 64'hffffffff00000000);
        send_hash(REQ_FIND,   64'h00000000ffffffff);
        send_hash(REQ_FIND,   64'hffffffff00000000);
        send_hash(REQ_INSERT, 64'h8000000080000000);
        send_hash(REQ_FIND,   64'h8000000080000000);
        settle();

        // zero block count folds every hash onto block 0
        write_blocks(11'd0);
        send_hash(REQ_INSERT, 64'hdeadbeef12345678);
        send_hash(REQ_FIND,   64'h0000000012345678);
        send_hash(REQ_FIND,   64'h1234567800000001);
        settle();

        // count above the store size saturates
        write_blocks(11'd2047);
        send_hash(REQ_INSERT, 64'hffffffffa5a5a5a5);
        send_hash(REQ_FIND,   64'hffffffffa5a5a5a5);
        send_hash(REQ_FIND,   64'hffffffff5a5a5a5a);
        settle();

        // count not a power of two
        write_blocks(11'd3);
        send_hash(REQ_INSERT, 64'haaaaaaaa55555555);
        send_hash(REQ_FIND,   64'haaaaaaaa55555555);
        send_hash(REQ_FIND,   64'h55555555aaaaaaaa);
        settle();

        // single block: earlier bits are kept across the change
        write_blocks(11'd1);
        send_hash(REQ_FIND,   64'h0123456789abcdef);
        send_hash(REQ_FIND,   64'h0000000012345678);
        settle();

        run_phase(11'd1024);
        run_phase(11'd1);
        run_phase(11'd2);
        run_phase(11'd3);
        run_phase(11'd16);
        run_phase(11'd100);
        run_phase(11'd512);
        run_phase(11'd0);
        run_phase(11'd2047);
        run_phase(11'($urandom_range(1, 1024)));

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
